// File: sv/alc_pkg.sv
// Package for the ambient light lux calculator: payload structs, segment codes,
// ratio limits and Q0.32 coefficients. No dependencies.
`default_nettype none
package alc_pkg;

  typedef struct packed {
    logic [15:0] broadband;
    logic [15:0] infrared;
  } alc_in_t;

  typedef struct packed {
    logic [26:0] lux_q16;
    logic [2:0]  segment;
  } alc_out_t;

  localparam logic [2:0] SEG_ZERO = 3'd0;
  localparam logic [2:0] SEG_ONE  = 3'd1;
  localparam logic [2:0] SEG_TWO  = 3'd2;
  localparam logic [2:0] SEG_THREE = 3'd3;
  localparam logic [2:0] SEG_FOUR = 3'd4;
  localparam logic [2:0] SEG_OVER = 3'd5;

  localparam int RatioW = 18;
  localparam logic [RatioW-1:0] RATIO_MAX = 18'h3FFFF;
  localparam logic [RatioW-1:0] LIM_050 = 18'd32768;
  localparam logic [RatioW-1:0] LIM_061 = 18'd39976;
  localparam logic [RatioW-1:0] LIM_080 = 18'd52428;
  localparam logic [RatioW-1:0] LIM_130 = 18'd85196;

  localparam logic [26:0] K_0304  = 27'd130567006;
  localparam logic [27:0] K_062   = 28'd266287972;
  localparam logic [26:0] K_0224  = 27'd96207267;
  localparam logic [27:0] K_031   = 28'd133143986;
  localparam logic [26:0] K_0128  = 27'd54975581;
  localparam logic [27:0] K_0153  = 28'd65713000;
  localparam logic [26:0] K_00146 = 27'd6270652;
  localparam logic [27:0] K_00112 = 28'd4810363;

  localparam logic [26:0] LUX_MAX = 27'h7FFFFFF;

endpackage
`default_nettype wire

// File: sv/alc_div.sv
// Pipelined restoring divider: ratio = floor(infrared * 2^16 / broadband),
// one quotient bit per stage. Depends on alc_pkg.
`default_nettype none
module alc_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire alc_pkg::alc_in_t in_data,
  output logic                 out_valid,
  output logic [17:0]          out_ratio,
  output alc_pkg::alc_in_t     out_data
);
  import alc_pkg::*;

  localparam int Steps = RatioW;

  logic           v_r   [0:Steps-1];
  logic [15:0]    rem_r [0:Steps-1];
  logic [RatioW-1:0] q_r [0:Steps-1];
  alc_in_t        pay_r [0:Steps-1];

  for (genvar j = 0; j < Steps; j++) begin : g_stage
    logic           v_in;
    logic [15:0]    rem_in;
    logic [RatioW-1:0] q_in;
    alc_in_t        pay_in;
    logic           nbit;
    logic [16:0]    sh;
    logic           ge;
    logic [15:0]    rem_nxt;
    logic [RatioW-1:0] q_nxt;

    // Pick stage input: ports for the first step, previous stage otherwise
    if (j == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = {2'b00, in_data.infrared[15:2]};
      assign q_in   = '0;
      assign pay_in = in_data;
    end else begin : g_next
      assign v_in   = v_r[j-1];
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign pay_in = pay_r[j-1];
    end

    // Numerator bit: infrared[1:0] feed the first two steps, zeros after
    if (j < 2) begin : g_nb
      assign nbit = pay_in.infrared[1-j];
    end else begin : g_nz
      assign nbit = 1'b0;
    end

    // Trial subtract and set one quotient bit
    always_comb begin
      sh      = {rem_in, nbit};
      ge      = (sh >= {1'b0, pay_in.broadband});
      rem_nxt = ge ? 16'(sh - {1'b0, pay_in.broadband}) : sh[15:0];
      q_nxt   = q_in;
      q_nxt[Steps-1-j] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        pay_r[j] <= pay_in;
      end
    end
  end

  assign out_valid = v_r[Steps-1];
  assign out_ratio = q_r[Steps-1];
  assign out_data  = pay_r[Steps-1];

endmodule
`default_nettype wire

// File: sv/ambient_light_lux_calc.sv
// Top level of the two-channel ambient light lux calculator: divider,
// segment select, power-table interpolation and lux formulas. Uses alc_pkg, alc_div.
//
//  channel | ports                         | payload
//  --------+-------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data   | broadband[15:0], infrared[15:0]
//  result  | out_valid, out_ready, out_data| lux_q16[26:0], segment[2:0]
//
// One transaction per cycle unless the output stalls; 18 divider steps,
// 5 formula stages, an output register. Reset clears all valid bits only.
// A stalled output parks one result in a skid register; in_ready drops
// while that register is full and the whole pipeline holds.
`default_nettype none
module ambient_light_lux_calc #(
  parameter int POWER_TABLE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire alc_pkg::alc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output alc_pkg::alc_out_t     out_data
);
  import alc_pkg::*;

  localparam int IdxW = $clog2(POWER_TABLE_DEPTH + 1);
  localparam int PosW = 16 + IdxW;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(POWER_TABLE_DEPTH);

  // Table entry k: floor(2^16 * x^1.4), x = floor(k*2^15/D)/2^16
  function automatic logic [15:0] pow_entry(input int k);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    logic [15:0]  x16;
    x16 = 16'((k * 32768) / POWER_TABLE_DEPTH);
    rhs = 128'd1;
    for (int n = 0; n < 7; n++) rhs = rhs * 128'(x16);
    lo = '0;
    hi = 17'd65535;
    for (int it = 0; it < 17; it++) begin
      if (lo < hi) begin
        mid = 17'((18'(lo) + 18'(hi) + 18'd1) >> 1);
        lhs = 128'd1 << 32;
        for (int n = 0; n < 5; n++) lhs = lhs * 128'(mid);
        if (lhs <= rhs) lo = mid;
        else hi = 17'(mid - 17'd1);
      end
    end
    return lo[15:0];
  endfunction

  logic [15:0] pow_rom [0:POWER_TABLE_DEPTH];
  for (genvar k = 0; k <= POWER_TABLE_DEPTH; k++) begin : g_rom
    assign pow_rom[k] = pow_entry(k);
  end

  // Pipeline enable: hold the divider and formula stages while the skid register is full
  logic     skid_v_r;
  alc_out_t skid_d_r;
  logic     out_v_r;
  alc_out_t out_d_r;
  logic     en;

  assign en       = ~skid_v_r;
  assign in_ready = en;

  // Divider
  logic        dv_valid;
  logic [17:0] dv_q;
  alc_in_t     dv_data;

  alc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (dv_valid),
    .out_ratio (dv_q),
    .out_data  (dv_data)
  );

  // Stage 1: saturate ratio, pick segment, table position and coefficients
  logic [RatioW-1:0] ratio;
  logic              sat;
  logic [2:0]        seg_nxt;
  logic [PosW-1:0]   pos;
  logic [26:0]       ka_nxt;
  logic [27:0]       kb_nxt;

  always_comb begin
    sat   = ({2'b00, dv_data.infrared} >= {dv_data.broadband, 2'b00});
    ratio = sat ? RATIO_MAX : dv_q;
    if (dv_data.broadband == 16'd0) seg_nxt = SEG_ZERO;
    else if (ratio <= LIM_050)      seg_nxt = SEG_ONE;
    else if (ratio <= LIM_061)      seg_nxt = SEG_TWO;
    else if (ratio <= LIM_080)      seg_nxt = SEG_THREE;
    else if (ratio <= LIM_130)      seg_nxt = SEG_FOUR;
    else                            seg_nxt = SEG_OVER;
    pos = PosW'(ratio[15:0]) * PosW'(POWER_TABLE_DEPTH);
    case (seg_nxt)
      SEG_TWO: begin
        ka_nxt = K_0224;
        kb_nxt = K_031;
      end
      SEG_THREE: begin
        ka_nxt = K_0128;
        kb_nxt = K_0153;
      end
      SEG_FOUR: begin
        ka_nxt = K_00146;
        kb_nxt = K_00112;
      end
      default: begin
        ka_nxt = '0;
        kb_nxt = '0;
      end
    endcase
  end

  logic            v1_r;
  logic [2:0]      seg1_r;
  logic [15:0]     bb1_r;
  logic [15:0]     ir1_r;
  logic [IdxW-1:0] idx1_r;
  logic [14:0]     frac1_r;
  logic [26:0]     ka1_r;
  logic [27:0]     kb1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      seg1_r  <= seg_nxt;
      bb1_r   <= dv_data.broadband;
      ir1_r   <= dv_data.infrared;
      idx1_r  <= pos[15 +: IdxW];
      frac1_r <= pos[14:0];
      ka1_r   <= ka_nxt;
      kb1_r   <= kb_nxt;
    end
  end

  // Stage 2: table read and linear-segment products
  // Clamp both table addresses to the last entry
  logic [IdxW-1:0] idx_lo;
  logic [IdxW-1:0] idx_up;
  assign idx_lo = (idx1_r >= IdxLast) ? IdxLast : idx1_r;
  assign idx_up = (idx1_r >= IdxLast) ? IdxLast : IdxW'(idx1_r + 1'b1);

  logic        v2_r;
  logic [2:0]  seg2_r;
  logic [15:0] bb2_r;
  logic [15:0] e0_r;
  logic [15:0] e1_r;
  logic [14:0] frac2_r;
  logic [42:0] pa2_r;
  logic [43:0] pb2_r;
  logic [42:0] f2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      seg2_r  <= seg1_r;
      bb2_r   <= bb1_r;
      e0_r    <= pow_rom[idx_lo];
      e1_r    <= pow_rom[idx_up];
      frac2_r <= frac1_r;
      pa2_r   <= 43'(ka1_r) * 43'(bb1_r);
      pb2_r   <= 44'(kb1_r) * 44'(ir1_r);
      f2_r    <= 43'(K_0304) * 43'(bb1_r);
    end
  end

  // Stage 3: interpolate ratio^1.4
  logic [15:0] dlt;
  logic [31:0] dprod;
  assign dlt   = (e1_r > e0_r) ? 16'(e1_r - e0_r) : 16'd0;
  assign dprod = 32'(dlt) * 32'(frac2_r) + 32'd16384;

  logic        v3_r;
  logic [2:0]  seg3_r;
  logic [15:0] bb3_r;
  logic [15:0] p3_r;
  logic [42:0] pa3_r;
  logic [43:0] pb3_r;
  logic [42:0] f3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      seg3_r <= seg2_r;
      bb3_r  <= bb2_r;
      p3_r   <= 16'(e0_r + dprod[30:15]);
      pa3_r  <= pa2_r;
      pb3_r  <= pb2_r;
      f3_r   <= f2_r;
    end
  end

  // Stage 4: broadband times power
  logic        v4_r;
  logic [2:0]  seg4_r;
  logic [31:0] bbp4_r;
  logic [42:0] pa4_r;
  logic [43:0] pb4_r;
  logic [42:0] f4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      seg4_r <= seg3_r;
      bbp4_r <= 32'(bb3_r) * 32'(p3_r);
      pa4_r  <= pa3_r;
      pb4_r  <= pb3_r;
      f4_r   <= f3_r;
    end
  end

  // Stage 5: scale by the segment-one power-term coefficient
  logic        v5_r;
  logic [2:0]  seg5_r;
  logic [59:0] s5_r;
  logic [42:0] pa5_r;
  logic [43:0] pb5_r;
  logic [42:0] f5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      seg5_r <= seg4_r;
      s5_r   <= 60'(K_062) * 60'(bbp4_r);
      pa5_r  <= pa4_r;
      pb5_r  <= pb4_r;
      f5_r   <= f4_r;
    end
  end

  // Valid bits of the formula stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= dv_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Final: difference, round, clamp at zero and at full scale
  logic [59:0] first;
  logic [59:0] diff1;
  logic [43:0] diff2;
  logic [27:0] lux_w;
  alc_out_t    fin;

  always_comb begin
    first = {1'b0, f5_r, 16'd0};
    diff1 = 60'(first - s5_r + 60'h80000000);
    diff2 = 44'(44'(pa5_r) - pb5_r + 44'd32768);
    case (seg5_r)
      SEG_ONE:   lux_w = (s5_r >= first) ? 28'd0 : diff1[59:32];
      SEG_TWO,
      SEG_THREE,
      SEG_FOUR:  lux_w = (pb5_r >= 44'(pa5_r)) ? 28'd0 : diff2[43:16];
      default:   lux_w = 28'd0;
    endcase
    fin.lux_q16 = lux_w[27] ? LUX_MAX : lux_w[26:0];
    fin.segment = seg5_r;
  end

  // Output register with skid: park a result while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_ready) begin
      out_v_r <= v5_r;
    end else if (v5_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_d_r <= skid_d_r;
      end
    end else if (!out_v_r || out_ready) begin
      out_d_r <= fin;
    end else begin
      skid_d_r <= fin;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // Skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid full with empty output register");

  // A waiting result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> out_v_r)
    else $error("pending result lost");

  // Zero broadband and over-range ratio give zero lux
  a_zero_lux: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_d_r.segment == SEG_ZERO || out_d_r.segment == SEG_OVER))
      |-> (out_d_r.lux_q16 == 27'd0))
    else $error("nonzero lux for zero or over-range segment");

  // Segment codes stay in range
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_d_r.segment <= SEG_OVER))
    else $error("segment code out of range");

endmodule
`default_nettype wire
